// ===== rtl/swsort_pkg.sv =====
// ----------------------------------------------------------------------------
// swsort_pkg: shared types and constants of the sliding window sorter
// Window depth, field widths, the empty marker and the cell control bundle.
// ----------------------------------------------------------------------------
package swsort_pkg;

    localparam int WINDOW = 8;
    localparam int DATA_W = 32;
    localparam int RANK_W = 3;
    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);

    localparam logic signed [DATA_W-1:0] EMPTY_MARK = -32'sd1;
    localparam logic [IDX_W-1:0] OLDEST_AGE = IDX_W'(WINDOW - 1);
    localparam logic [IDX_W-1:0] LAST_PHASE = IDX_W'(WINDOW - 1);

    typedef logic [WINDOW-1:0][DATA_W-1:0] win_t;

    // per-cell control for one clock
    typedef struct packed {
        logic load;       // new sample replaces the oldest entry
        logic sort;       // odd-even exchange phase
        logic take_low;   // cell is the lower member of its pair
        logic take_high;  // cell is the upper member of its pair
    } cell_ctrl_t;

endpackage

// ===== rtl/swsort_cell.sv =====
// ----------------------------------------------------------------------------
// swsort_cell: one slot of the sorted window
// Holds a sample and its age; replaces itself when oldest and trades places
// with a neighbor during the odd-even exchange phases.
// ----------------------------------------------------------------------------
module swsort_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  swsort_pkg::cell_ctrl_t              ctrl,
    input  logic [swsort_pkg::IDX_W-1:0]        init_age,
    input  logic signed [swsort_pkg::DATA_W-1:0] sample,
    input  logic signed [swsort_pkg::DATA_W-1:0] left_val,
    input  logic [swsort_pkg::IDX_W-1:0]        left_age,
    input  logic signed [swsort_pkg::DATA_W-1:0] right_val,
    input  logic [swsort_pkg::IDX_W-1:0]        right_age,
    output logic signed [swsort_pkg::DATA_W-1:0] val,
    output logic [swsort_pkg::IDX_W-1:0]        age
);

    logic signed [swsort_pkg::DATA_W-1:0] val_reg, val_next;
    logic [swsort_pkg::IDX_W-1:0]         age_reg, age_next;

    always_comb begin
        val_next = val_reg;
        age_next = age_reg;
        if (ctrl.load) begin
            if (age_reg == swsort_pkg::OLDEST_AGE) begin
                val_next = sample;
                age_next = '0;
            end else begin
                age_next = age_reg + 1'b1;
            end
        end else if (ctrl.sort) begin
            if (ctrl.take_low && (right_val < val_reg)) begin
                val_next = right_val;
                age_next = right_age;
            end else if (ctrl.take_high && (left_val > val_reg)) begin
                val_next = left_val;
                age_next = left_age;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= swsort_pkg::EMPTY_MARK;
            age_reg <= init_age;
        end else begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

    assign val = val_reg;
    assign age = age_reg;

endmodule

// ===== rtl/swsort_drain.sv =====
// ----------------------------------------------------------------------------
// swsort_drain: result shift chain
// Takes a snapshot of the sorted window and shifts it out smallest first,
// one transaction per accepted result.
// ----------------------------------------------------------------------------
module swsort_drain (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 load,
    input  swsort_pkg::win_t                     load_vals,
    input  logic                                 load_full,
    output logic                                 can_load,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [swsort_pkg::DATA_W-1:0] m_sorted_value,
    output logic [swsort_pkg::RANK_W-1:0]        m_rank,
    output logic                                 m_last_of_run,
    output logic                                 m_window_full
);

    swsort_pkg::win_t                 val_reg, val_next;
    logic [swsort_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [swsort_pkg::CNT_W-1:0]     left_reg, left_next;
    logic                             full_reg, full_next;
    logic                             pop;

    assign pop      = m_valid && m_ready;
    assign can_load = (left_reg == '0) || ((left_reg == swsort_pkg::CNT_W'(1)) && m_ready);

    always_comb begin
        val_next  = val_reg;
        idx_next  = idx_reg;
        left_next = left_reg;
        full_next = full_reg;
        if (load) begin
            val_next  = load_vals;
            idx_next  = '0;
            left_next = swsort_pkg::CNT_W'(swsort_pkg::WINDOW);
            full_next = load_full;
        end else if (pop) begin
            val_next  = swsort_pkg::win_t'(val_reg >> swsort_pkg::DATA_W);
            idx_next  = idx_reg + 1'b1;
            left_next = left_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
            idx_reg  <= '0;
        end else begin
            left_reg <= left_next;
            idx_reg  <= idx_next;
        end
        val_reg  <= val_next;
        full_reg <= full_next;
    end

    assign m_valid        = (left_reg != '0);
    assign m_sorted_value = $signed(val_reg[0]);
    assign m_rank         = swsort_pkg::RANK_W'(idx_reg);
    assign m_last_of_run  = (left_reg == swsort_pkg::CNT_W'(1));
    assign m_window_full  = full_reg;

endmodule

// ===== rtl/sliding_window_sorter.sv =====
// ----------------------------------------------------------------------------
// sliding_window_sorter: sliding window sort for a median filter
// Each sample replaces the oldest of WINDOW entries; the window is then put
// in ascending order and sent out as WINDOW results.
// ----------------------------------------------------------------------------
// One sample is taken per transaction on the s_ channel. The window lives in
// a row of WINDOW cells kept in sorted order; each cell carries its sample's
// age. On acceptance the oldest cell takes the new sample, then WINDOW
// odd-even exchange phases between neighboring cells restore the order. The
// sorted row is copied into an output shift chain and emitted smallest
// first, one result per cycle while m_ready is high. The input is busy with
// each sample through the replace, the WINDOW exchange phases and the copy,
// and the copy waits while the previous run is still draining. The window
// resets to all -1, and m_window_full is low for a run whose copied window
// held any entry equal to -1.
// ----------------------------------------------------------------------------
module sliding_window_sorter (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [swsort_pkg::DATA_W-1:0] s_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [swsort_pkg::DATA_W-1:0] m_sorted_value,
    output logic [swsort_pkg::RANK_W-1:0]        m_rank,
    output logic                                 m_last_of_run,
    output logic                                 m_window_full
);

    logic                         sort_active_reg, sort_active_next;
    logic                         done_reg, done_next;
    logic [swsort_pkg::IDX_W-1:0] phase_reg, phase_next;
    logic                         accept;
    logic                         can_load;
    logic                         load_out;

    swsort_pkg::win_t             cell_val;
    logic [swsort_pkg::IDX_W-1:0] cell_age [swsort_pkg::WINDOW];
    logic [swsort_pkg::WINDOW-1:0] not_empty;
    swsort_pkg::cell_ctrl_t       cell_ctrl [swsort_pkg::WINDOW];

    assign s_ready  = !sort_active_reg && !done_reg;
    assign accept   = s_valid && s_ready;
    assign load_out = done_reg && can_load;

    always_comb begin
        sort_active_next = sort_active_reg;
        done_next        = done_reg;
        phase_next       = phase_reg;
        if (accept) begin
            sort_active_next = 1'b1;
            phase_next       = '0;
        end else if (sort_active_reg) begin
            phase_next = phase_reg + 1'b1;
            if (phase_reg == swsort_pkg::LAST_PHASE) begin
                sort_active_next = 1'b0;
                done_next        = 1'b1;
            end
        end else if (load_out) begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sort_active_reg <= 1'b0;
            done_reg        <= 1'b0;
            phase_reg       <= '0;
        end else begin
            sort_active_reg <= sort_active_next;
            done_reg        <= done_next;
            phase_reg       <= phase_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < swsort_pkg::WINDOW; i++) begin : g_cell
            logic signed [swsort_pkg::DATA_W-1:0] lv, rv;
            logic [swsort_pkg::IDX_W-1:0]         la, ra;

            // pairs start at even cells on even phases, odd cells on odd phases
            always_comb begin
                cell_ctrl[i].load      = accept;
                cell_ctrl[i].sort      = sort_active_reg;
                cell_ctrl[i].take_low  = (phase_reg[0] == 1'(i % 2)) &&
                                         (i < swsort_pkg::WINDOW - 1);
                cell_ctrl[i].take_high = (phase_reg[0] != 1'(i % 2)) && (i > 0);
            end

            if (i > 0) begin : g_left
                assign lv = $signed(cell_val[i-1]);
                assign la = cell_age[i-1];
            end else begin : g_left_edge
                assign lv = $signed(cell_val[i]);
                assign la = cell_age[i];
            end

            if (i < swsort_pkg::WINDOW - 1) begin : g_right
                assign rv = $signed(cell_val[i+1]);
                assign ra = cell_age[i+1];
            end else begin : g_right_edge
                assign rv = $signed(cell_val[i]);
                assign ra = cell_age[i];
            end

            swsort_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (cell_ctrl[i]),
                .init_age  (swsort_pkg::IDX_W'(i)),
                .sample    (s_sample),
                .left_val  (lv),
                .left_age  (la),
                .right_val (rv),
                .right_age (ra),
                .val       (cell_val[i]),
                .age       (cell_age[i])
            );

            assign not_empty[i] = ($signed(cell_val[i]) != swsort_pkg::EMPTY_MARK);
        end
    endgenerate

    swsort_drain u_drain (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (load_out),
        .load_vals      (cell_val),
        .load_full      (&not_empty),
        .can_load       (can_load),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_rank         (m_rank),
        .m_last_of_run  (m_last_of_run),
        .m_window_full  (m_window_full)
    );

    // accepted transaction always starts a sort pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> sort_active_reg && (phase_reg == '0))
        else $error("sort pass did not start after input transaction");

    // last exchange phase hands over to the copy stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (sort_active_reg && (phase_reg == swsort_pkg::LAST_PHASE) && !accept)
        |=> done_reg && !sort_active_reg)
        else $error("sort pass did not finish after the last phase");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(sort_active_reg && done_reg))
        else $error("sorting and copy pending at once");

    // final result of a run carries the top rank
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_of_run) |-> (m_rank == swsort_pkg::RANK_W'(swsort_pkg::WINDOW - 1)))
        else $error("last result has wrong rank");

endmodule
